@@ hdl/ps2sd_pkg.sv @@
// Package for the PS/2 set 2 scancode decoder: event and result types,
// scancode constants and the key map functions. No dependencies.
`timescale 1ns / 1ps

package ps2sd_pkg;

    // Queue between the front and back parts
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;
    localparam int Q_CW    = 2;

    // Prefix bytes
    localparam logic [7:0] SC_EXT_PREFIX = 8'hE0;
    localparam logic [7:0] SC_BRK_PREFIX = 8'hF0;

    // Modifier and lock codes
    localparam logic [7:0] SC_LSHIFT = 8'h12;
    localparam logic [7:0] SC_RSHIFT = 8'h59;
    localparam logic [7:0] SC_CTRL   = 8'h14;
    localparam logic [7:0] SC_ALT    = 8'h11;
    localparam logic [7:0] SC_CAPS   = 8'h58;
    localparam logic [7:0] SC_NUMLK  = 8'h77;
    localparam logic [7:0] SC_SCROLL = 8'h7E;
    localparam logic [7:0] SC_LWIN   = 8'h1F;
    localparam logic [7:0] SC_RWIN   = 8'h27;

    // Special key codes start here
    localparam logic [7:0] VK_BASE = 8'h80;

    // One completed key event, from front to back
    typedef struct packed {
        logic [7:0] code;
        logic       ext;
        logic       make;
    } key_event_t;

    // Key map lookup result
    typedef struct packed {
        logic       known;
        logic [7:0] ch;
        logic       valid;
    } key_lookup_t;

    // One result word
    typedef struct packed {
        logic       known_key;
        logic [7:0] key_code;
        logic       pressed;
        logic       extended;
        logic [7:0] char_value;
        logic       char_valid;
        logic       shift_down;
        logic       ctrl_down;
        logic       alt_down;
        logic       caps_on;
        logic       numlk_on;
        logic       scroll_on;
    } key_result_t;

    // Lower case letter for a scancode, zero if not a letter
    function automatic logic [7:0] letter_of(input logic [7:0] sc);
        logic [7:0] c;
        begin
            unique case (sc)
                8'h15: c = "q"; 8'h1D: c = "w"; 8'h24: c = "e";
                8'h2D: c = "r"; 8'h2C: c = "t"; 8'h35: c = "y";
                8'h3C: c = "u"; 8'h43: c = "i"; 8'h44: c = "o";
                8'h4D: c = "p"; 8'h1C: c = "a"; 8'h1B: c = "s";
                8'h23: c = "d"; 8'h2B: c = "f"; 8'h34: c = "g";
                8'h33: c = "h"; 8'h3B: c = "j"; 8'h42: c = "k";
                8'h4B: c = "l"; 8'h1A: c = "z"; 8'h22: c = "x";
                8'h21: c = "c"; 8'h2A: c = "v"; 8'h32: c = "b";
                8'h31: c = "n"; 8'h3A: c = "m";
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    // Main block map (no E0 prefix)
    function automatic key_lookup_t map_main(input logic [7:0] sc, input logic sh,
                                             input logic ctrl, input logic caps,
                                             input logic numlk);
        key_lookup_t m;
        logic [7:0]  lo;
        begin
            lo = letter_of(sc);
            m.known = 1'b1;
            m.valid = 1'b1;
            m.ch    = 8'h00;
            if (lo != 8'h00)
            begin
                if (ctrl)
                    m.ch = lo - 8'h60;
                else if (sh ^ caps)
                    m.ch = lo - 8'h20;
                else
                    m.ch = lo;
            end
            else
            begin
                unique case (sc)
                    8'h0E: m.ch = sh ? "~" : 8'h60;
                    8'h16: m.ch = sh ? "!" : "1";
                    8'h1E: m.ch = sh ? "@" : "2";
                    8'h26: m.ch = sh ? "#" : "3";
                    8'h25: m.ch = sh ? "$" : "4";
                    8'h2E: m.ch = sh ? "%" : "5";
                    8'h36: m.ch = sh ? "^" : "6";
                    8'h3D: m.ch = sh ? "&" : "7";
                    8'h3E: m.ch = sh ? "*" : "8";
                    8'h46: m.ch = sh ? "(" : "9";
                    8'h45: m.ch = sh ? ")" : "0";
                    8'h4E: m.ch = sh ? "_" : "-";
                    8'h55: m.ch = sh ? "+" : "=";
                    8'h54: m.ch = sh ? "{" : "[";
                    8'h5B: m.ch = sh ? "}" : "]";
                    8'h5D: m.ch = sh ? 8'h7C : 8'h5C;
                    8'h4C: m.ch = sh ? ":" : ";";
                    8'h52: m.ch = sh ? 8'h22 : 8'h27;
                    8'h41: m.ch = sh ? "<" : ",";
                    8'h49: m.ch = sh ? ">" : ".";
                    8'h4A: m.ch = sh ? "?" : "/";
                    8'h66: m.ch = 8'h08;
                    8'h0D: m.ch = 8'h09;
                    8'h5A: m.ch = 8'h0D;
                    8'h29: m.ch = 8'h20;
                    8'h76: m.ch = 8'h1B;
                    8'h79: m.ch = "+";
                    8'h7B: m.ch = "-";
                    8'h7C: m.ch = "*";
                    // keypad digits follow num lock
                    8'h70: begin m.ch = "0"; m.valid = numlk; end
                    8'h69: begin m.ch = "1"; m.valid = numlk; end
                    8'h72: begin m.ch = "2"; m.valid = numlk; end
                    8'h7A: begin m.ch = "3"; m.valid = numlk; end
                    8'h6B: begin m.ch = "4"; m.valid = numlk; end
                    8'h73: begin m.ch = "5"; m.valid = numlk; end
                    8'h74: begin m.ch = "6"; m.valid = numlk; end
                    8'h6C: begin m.ch = "7"; m.valid = numlk; end
                    8'h75: begin m.ch = "8"; m.valid = numlk; end
                    8'h7D: begin m.ch = "9"; m.valid = numlk; end
                    8'h71: begin m.ch = "."; m.valid = numlk; end
                    // function keys
                    8'h05: begin m.ch = VK_BASE + 8'd0;  m.valid = 1'b0; end
                    8'h06: begin m.ch = VK_BASE + 8'd1;  m.valid = 1'b0; end
                    8'h04: begin m.ch = VK_BASE + 8'd2;  m.valid = 1'b0; end
                    8'h0C: begin m.ch = VK_BASE + 8'd3;  m.valid = 1'b0; end
                    8'h03: begin m.ch = VK_BASE + 8'd4;  m.valid = 1'b0; end
                    8'h0B: begin m.ch = VK_BASE + 8'd5;  m.valid = 1'b0; end
                    8'h83: begin m.ch = VK_BASE + 8'd6;  m.valid = 1'b0; end
                    8'h0A: begin m.ch = VK_BASE + 8'd7;  m.valid = 1'b0; end
                    8'h01: begin m.ch = VK_BASE + 8'd8;  m.valid = 1'b0; end
                    8'h09: begin m.ch = VK_BASE + 8'd9;  m.valid = 1'b0; end
                    8'h78: begin m.ch = VK_BASE + 8'd10; m.valid = 1'b0; end
                    8'h07: begin m.ch = VK_BASE + 8'd11; m.valid = 1'b0; end
                    default:
                    begin
                        m.ch    = 8'h00;
                        m.valid = 1'b0;
                        m.known = 1'b0;
                    end
                endcase
            end
            return m;
        end
    endfunction

    // Extended (E0) map
    function automatic key_lookup_t map_ext(input logic [7:0] sc);
        key_lookup_t m;
        begin
            m.known = 1'b1;
            m.valid = 1'b0;
            m.ch    = 8'h00;
            unique case (sc)
                8'h69: m.ch = VK_BASE + 8'd12;
                8'h6B: m.ch = VK_BASE + 8'd13;
                8'h6C: m.ch = VK_BASE + 8'd14;
                8'h70: m.ch = VK_BASE + 8'd15;
                8'h72: m.ch = VK_BASE + 8'd16;
                8'h74: m.ch = VK_BASE + 8'd17;
                8'h75: m.ch = VK_BASE + 8'd18;
                8'h7A: m.ch = VK_BASE + 8'd19;
                8'h7D: m.ch = VK_BASE + 8'd20;
                8'h2F: m.ch = VK_BASE + 8'd21;
                8'h71: begin m.ch = 8'h7F; m.valid = 1'b1; end
                8'h5A: begin m.ch = 8'h0D; m.valid = 1'b1; end
                8'h4A: begin m.ch = "/";   m.valid = 1'b1; end
                default: m.known = 1'b0;
            endcase
            return m;
        end
    endfunction

endpackage

@@ hdl/ps2sd_front.sv @@
// Front part: takes raw bytes, absorbs E0/F0 prefixes and pushes completed
// key events into the queue. Depends on ps2sd_pkg.
`timescale 1ns / 1ps

module ps2sd_front
    import ps2sd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       scan_valid,
    output logic       scan_ready,
    input  logic [7:0] scan_byte,
    input  logic       q_full,
    output logic       q_push,
    output key_event_t q_wdata
);

    logic ext_pending_reg,   ext_pending_next;
    logic break_pending_reg, break_pending_next;
    logic accept;
    logic is_ext, is_brk;

    // Classify the incoming byte
    assign scan_ready = !q_full;
    assign accept     = scan_valid && scan_ready;
    assign is_ext     = (scan_byte == SC_EXT_PREFIX);
    assign is_brk     = (scan_byte == SC_BRK_PREFIX);

    // Event word for the queue
    assign q_push       = accept && !is_ext && !is_brk;
    assign q_wdata.code = scan_byte;
    assign q_wdata.ext  = ext_pending_reg;
    assign q_wdata.make = !break_pending_reg;

    // Prefix flags: set by their prefix, cleared by any accepted non-prefix byte
    always_comb
    begin
        ext_pending_next   = ext_pending_reg;
        break_pending_next = break_pending_reg;
        if (accept)
        begin
            priority if (is_ext)
                ext_pending_next = 1'b1;
            else if (is_brk)
                break_pending_next = 1'b1;
            else
            begin
                ext_pending_next   = 1'b0;
                break_pending_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_pending_reg   <= 1'b0;
            break_pending_reg <= 1'b0;
        end
        else
        begin
            ext_pending_reg   <= ext_pending_next;
            break_pending_reg <= break_pending_next;
        end
    end

endmodule

@@ hdl/ps2sd_queue.sv @@
// Short event queue between front and back parts.
// Depends on ps2sd_pkg.
`timescale 1ns / 1ps

module ps2sd_queue
    import ps2sd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  key_event_t wdata,
    input  logic       pop,
    output key_event_t rdata,
    output logic       full,
    output logic       empty
);

    key_event_t            entry_reg [Q_DEPTH];
    logic [Q_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]       count_reg,  count_next;

    assign full  = (count_reg == Q_CW'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = entry_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

endmodule

@@ hdl/ps2sd_back.sv @@
// Back part: tracks modifiers and locks, maps key events to characters and
// holds the result in an output register. Depends on ps2sd_pkg.
`timescale 1ns / 1ps

module ps2sd_back
    import ps2sd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  key_event_t  q_rdata,
    output logic        q_pop,
    output logic        result_valid,
    input  logic        result_ready,
    output key_result_t result
);

    logic lshift_reg, lshift_next;
    logic rshift_reg, rshift_next;
    logic lctrl_reg,  lctrl_next;
    logic rctrl_reg,  rctrl_next;
    logic lalt_reg,   lalt_next;
    logic ralt_reg,   ralt_next;
    logic caps_reg,   caps_next;
    logic numlk_reg,  numlk_next;
    logic scroll_reg, scroll_next;
    logic        out_valid_reg, out_valid_next;
    key_result_t result_reg,    result_next;
    key_lookup_t map_main_w, map_ext_w, map_sel;
    logic        is_mod;
    logic        sh, ctrl, mk;
    logic [7:0]  code;

    // Take the next event when the output register is free or draining
    assign q_pop = !q_empty && (!out_valid_reg || result_ready);

    assign code = q_rdata.code;
    assign mk   = q_rdata.make;
    assign sh   = lshift_reg | rshift_reg;
    assign ctrl = lctrl_reg | rctrl_reg;

    assign map_main_w = map_main(code, sh, ctrl, caps_reg, numlk_reg);
    assign map_ext_w  = map_ext(code);

    // Modifier and lock tracking; win keys are recognized but not reported
    always_comb
    begin
        lshift_next = lshift_reg;
        rshift_next = rshift_reg;
        lctrl_next  = lctrl_reg;
        rctrl_next  = rctrl_reg;
        lalt_next   = lalt_reg;
        ralt_next   = ralt_reg;
        caps_next   = caps_reg;
        numlk_next  = numlk_reg;
        scroll_next = scroll_reg;
        is_mod      = 1'b1;
        if (q_rdata.ext)
        begin
            priority if (code == SC_CTRL)
                rctrl_next = mk;
            else if (code == SC_ALT)
                ralt_next = mk;
            else if (code == SC_LWIN || code == SC_RWIN)
                is_mod = 1'b1;
            else
                is_mod = 1'b0;
        end
        else
        begin
            priority if (code == SC_LSHIFT)
                lshift_next = mk;
            else if (code == SC_RSHIFT)
                rshift_next = mk;
            else if (code == SC_CTRL)
                lctrl_next = mk;
            else if (code == SC_ALT)
                lalt_next = mk;
            else if (code == SC_CAPS)
                caps_next = caps_reg ^ mk;
            else if (code == SC_NUMLK)
                numlk_next = numlk_reg ^ mk;
            else if (code == SC_SCROLL)
                scroll_next = scroll_reg ^ mk;
            else
                is_mod = 1'b0;
        end
    end

    // Result word
    always_comb
    begin
        if (is_mod)
        begin
            map_sel.known = 1'b1;
            map_sel.ch    = 8'h00;
            map_sel.valid = 1'b0;
        end
        else if (q_rdata.ext)
            map_sel = map_ext_w;
        else
            map_sel = map_main_w;

        result_next.known_key  = map_sel.known;
        result_next.key_code   = code;
        result_next.pressed    = mk;
        result_next.extended   = q_rdata.ext;
        result_next.char_value = map_sel.ch;
        result_next.char_valid = map_sel.valid;
        result_next.shift_down = lshift_next | rshift_next;
        result_next.ctrl_down  = lctrl_next | rctrl_next;
        result_next.alt_down   = lalt_next | ralt_next;
        result_next.caps_on    = caps_next;
        result_next.numlk_on   = numlk_next;
        result_next.scroll_on  = scroll_next;
    end

    // Output register valid
    always_comb
    begin
        if (q_pop)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lshift_reg    <= 1'b0;
            rshift_reg    <= 1'b0;
            lctrl_reg     <= 1'b0;
            rctrl_reg     <= 1'b0;
            lalt_reg      <= 1'b0;
            ralt_reg      <= 1'b0;
            caps_reg      <= 1'b0;
            numlk_reg     <= 1'b0;
            scroll_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                lshift_reg <= lshift_next;
                rshift_reg <= rshift_next;
                lctrl_reg  <= lctrl_next;
                rctrl_reg  <= rctrl_next;
                lalt_reg   <= lalt_next;
                ralt_reg   <= ralt_next;
                caps_reg   <= caps_next;
                numlk_reg  <= numlk_next;
                scroll_reg <= scroll_next;
            end
        end
    end

    // Payload register
    always_ff @(posedge clk)
    begin
        if (q_pop)
            result_reg <= result_next;
    end

endmodule

@@ hdl/ps2_set2_scancode_decoder.sv @@
// PS/2 set 2 scancode decoder top level: front, event queue and back.
// Depends on ps2sd_pkg, ps2sd_front, ps2sd_queue, ps2sd_back.
`timescale 1ns / 1ps

// Takes one keyboard byte per cycle on scan_valid/scan_ready while the
// event queue is not full. E0 and F0 prefix bytes are absorbed and
// give no word; every other byte gives one result word on
// result_valid/result_ready, carrying the key's character or special-key
// code and the modifier and lock state after that key. A byte that
// completes a key is written into the event queue when it is accepted
// and moves on into the output register, which drives result_valid, once
// that register is free or being taken; one byte per cycle is sustained
// while the output is taken. With the output stalled, the output register
// and the two-entry event queue hold three keys before scan_ready drops.
module ps2_set2_scancode_decoder
    import ps2sd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       scan_valid,
    output logic       scan_ready,
    input  logic [7:0] scan_byte,
    output logic       result_valid,
    input  logic       result_ready,
    output logic       known_key,
    output logic [7:0] key_code,
    output logic       pressed,
    output logic       extended,
    output logic [7:0] char_value,
    output logic       char_valid,
    output logic       shift_down,
    output logic       ctrl_down,
    output logic       alt_down,
    output logic       caps_on,
    output logic       numlk_on,
    output logic       scroll_on
);

    key_event_t  q_wdata, q_rdata;
    logic        q_push, q_pop, q_full, q_empty;
    key_result_t result;

    ps2sd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (scan_valid),
        .scan_ready (scan_ready),
        .scan_byte  (scan_byte),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_wdata    (q_wdata)
    );

    ps2sd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    ps2sd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_rdata      (q_rdata),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Unpack the result word
    assign known_key  = result.known_key;
    assign key_code   = result.key_code;
    assign pressed    = result.pressed;
    assign extended   = result.extended;
    assign char_value = result.char_value;
    assign char_valid = result.char_valid;
    assign shift_down = result.shift_down;
    assign ctrl_down  = result.ctrl_down;
    assign alt_down   = result.alt_down;
    assign caps_on    = result.caps_on;
    assign numlk_on   = result.numlk_on;
    assign scroll_on  = result.scroll_on;

endmodule
